### design/sclc_pkg.sv
// ----------------------------------------------------------------------------
// sclc_pkg
// Shared types, widths and helpers of the scan cluster leg classifier: beam
// and result beats, the cluster record passed between the front and the back,
// register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sclc_pkg;

	// sizing
	localparam int MAX_BEAMS   = 1024;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = $clog2(MAX_BEAMS);
	localparam int CNT_W       = $clog2(MAX_BEAMS + 1);
	localparam int EXT_W       = 33;
	localparam int PCT_W       = 7;
	localparam int MAG_W       = COORD_BITS + 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int SUM_W       = SQ_W + 1;
	localparam int WIDE_W      = (SUM_W > EXT_W) ? SUM_W : EXT_W;
	localparam int PROD_W      = CNT_W + PCT_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// classification constants
	localparam int PERCENT_SCALE  = 100;
	localparam int LEG_MIN_POINTS = 5;

	// register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [EXT_W-1:0] GAP_SQ_RST  = EXT_W'(40000);
	localparam logic [EXT_W-1:0] LEG_MIN_RST = EXT_W'(2500);
	localparam logic [EXT_W-1:0] LEG_MAX_RST = EXT_W'(62500);
	localparam logic [PCT_W-1:0] DYN_PCT_RST = PCT_W'(75);
	localparam logic [EXT_W-1:0] EXT_MAX     = '1;

	typedef enum logic [1:0] {
		REG_GAP_SQ  = 2'd0,
		REG_LEG_MIN = 2'd1,
		REG_LEG_MAX = 2'd2,
		REG_DYN_PCT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [EXT_W-1:0] gap_sq;
		logic [EXT_W-1:0] leg_min_sq;
		logic [EXT_W-1:0] leg_max_sq;
		logic [PCT_W-1:0] dynamic_percent;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         beam_moving;
		logic                         last_beam;
	} beam_t;

	typedef struct packed {
		logic [IDX_W-1:0]             cluster_number;
		logic [IDX_W-1:0]             first_beam;
		logic [CNT_W-1:0]             point_count;
		logic [EXT_W-1:0]             extent_sq;
		logic signed [COORD_BITS-1:0] middle_x;
		logic signed [COORD_BITS-1:0] middle_y;
		logic [CNT_W-1:0]             moving_count;
		logic                         is_leg;
		logic                         leg_moving;
		logic                         last_cluster;
	} result_t;

	// raw cluster snapshot: first and last beam, counts, numbering
	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [IDX_W-1:0]             start_idx;
		logic [CNT_W-1:0]             cnt;
		logic [CNT_W-1:0]             mov;
		logic [IDX_W-1:0]             cidx;
	} rec_t;

	// one queue entry: cluster closed by a gap and/or cluster closed by scan end
	typedef struct packed {
		logic gap_v;
		rec_t gap;
		logic fin_v;
		rec_t fin;
	} close_t;

	// magnitude of the difference of two coordinates
	function automatic logic [MAG_W-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [MAG_W-1:0] d;
		d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
		return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	// floor of the mean of two coordinates
	function automatic logic signed [COORD_BITS-1:0] half_sum(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [MAG_W-1:0] s;
		s = $signed({a[COORD_BITS-1], a}) + $signed({b[COORD_BITS-1], b});
		return s[MAG_W-1:1];
	endfunction

endpackage

`default_nettype wire

### design/sclc_csr.sv
// ----------------------------------------------------------------------------
// sclc_csr
// Register bank behind the APB-style port: gap threshold, leg extent limits
// and moving share.
// ----------------------------------------------------------------------------
`default_nettype none

module sclc_csr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sclc_pkg::ADDR_W-1:0]  paddr,
	input  logic [sclc_pkg::DATA_W-1:0]  pwdata,
	output logic [sclc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output sclc_pkg::cfg_t               cfg
);
	import sclc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_sq          <= GAP_SQ_RST;
			cfg_q.leg_min_sq      <= LEG_MIN_RST;
			cfg_q.leg_max_sq      <= LEG_MAX_RST;
			cfg_q.dynamic_percent <= DYN_PCT_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_GAP_SQ:  cfg_q.gap_sq          <= pwdata[EXT_W-1:0];
				REG_LEG_MIN: cfg_q.leg_min_sq      <= pwdata[EXT_W-1:0];
				REG_LEG_MAX: cfg_q.leg_max_sq      <= pwdata[EXT_W-1:0];
				REG_DYN_PCT: cfg_q.dynamic_percent <= pwdata[PCT_W-1:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (sel)
			REG_GAP_SQ:  prdata = DATA_W'(cfg_q.gap_sq);
			REG_LEG_MIN: prdata = DATA_W'(cfg_q.leg_min_sq);
			REG_LEG_MAX: prdata = DATA_W'(cfg_q.leg_max_sq);
			REG_DYN_PCT: prdata = DATA_W'(cfg_q.dynamic_percent);
		endcase
	end

endmodule

`default_nettype wire

### design/sclc_front.sv
// ----------------------------------------------------------------------------
// sclc_front
// Beam intake: gap distance to the previous beam over two stages, then the
// running cluster state; closed clusters are pushed as raw snapshots.
// ----------------------------------------------------------------------------
`default_nettype none

module sclc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        beam_valid,
	output logic                        beam_ready,
	input  sclc_pkg::beam_t             beam_data,
	input  logic [sclc_pkg::EXT_W-1:0]  gap_sq,
	output logic                        push,
	output sclc_pkg::close_t            push_data,
	input  logic                        full
);
	import sclc_pkg::*;

	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         acc, close_in;

	logic             v_s1, first_s1, close_s1;
	beam_t            beam_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [MAG_W-1:0] adx_s1, ady_s1;

	logic             v_s2, first_s2, close_s2;
	beam_t            beam_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;

	rec_t              clus_q, nxt;
	logic [WIDE_W-1:0] gap_dist;
	logic              gap, open, evt, go_s2, ce_s2, ce_s1;

	// stage enables
	assign evt        = gap | close_s2;
	assign go_s2      = v_s2 & (~evt | ~full);
	assign ce_s2      = ~v_s2 | go_s2;
	assign ce_s1      = ~v_s1 | ce_s2;
	assign beam_ready = ce_s1;
	assign acc        = beam_valid & beam_ready;
	assign close_in   = beam_data.last_beam | (idx_q == IDX_W'(MAX_BEAMS - 1));

	// previous beam and beam index at intake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			idx_q    <= '0;
		end else if (acc) begin
			prev_x_q <= beam_data.point_x;
			prev_y_q <= beam_data.point_y;
			idx_q    <= close_in ? '0 : idx_q + 1'b1;
		end
	end

	// stage 1: distance components
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce_s1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			beam_s1  <= beam_data;
			idx_s1   <= idx_q;
			first_s1 <= (idx_q == '0);
			close_s1 <= close_in;
			adx_s1   <= abs_diff(beam_data.point_x, prev_x_q);
			ady_s1   <= abs_diff(beam_data.point_y, prev_y_q);
		end
	end

	// stage 2: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce_s2 && v_s1) begin
			beam_s2  <= beam_s1;
			idx_s2   <= idx_s1;
			first_s2 <= first_s1;
			close_s2 <= close_s1;
			sqx_s2   <= SQ_W'(adx_s1 * adx_s1);
			sqy_s2   <= SQ_W'(ady_s1 * ady_s1);
		end
	end

	// gap decision and next cluster state
	always_comb begin
		gap_dist = WIDE_W'(sqx_s2) + WIDE_W'(sqy_s2);
		gap      = ~first_s2 & (gap_dist > WIDE_W'(gap_sq));
		open     = first_s2 | gap;
		nxt      = clus_q;
		if (open) begin
			nxt.start_x   = beam_s2.point_x;
			nxt.start_y   = beam_s2.point_y;
			nxt.start_idx = idx_s2;
			nxt.cnt       = CNT_W'(1);
			nxt.mov       = CNT_W'(beam_s2.beam_moving);
			nxt.cidx      = first_s2 ? '0 : clus_q.cidx + 1'b1;
		end else begin
			nxt.cnt = clus_q.cnt + 1'b1;
			nxt.mov = clus_q.mov + CNT_W'(beam_s2.beam_moving);
		end
		nxt.end_x = beam_s2.point_x;
		nxt.end_y = beam_s2.point_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clus_q <= '0;
		end else if (go_s2) begin
			clus_q <= nxt;
		end
	end

	// closed clusters toward the queue
	assign push            = go_s2 & evt;
	assign push_data.gap_v = gap;
	assign push_data.gap   = clus_q;
	assign push_data.fin_v = close_s2;
	assign push_data.fin   = nxt;

endmodule

`default_nettype wire

### design/sclc_queue.sv
// ----------------------------------------------------------------------------
// sclc_queue
// Small first-in first-out store of closed-cluster entries between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sclc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sclc_pkg::close_t  push_data,
	output logic              full,
	input  logic              pop,
	output sclc_pkg::close_t  head,
	output logic              head_valid
);
	import sclc_pkg::*;

	close_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/sclc_back.sv
// ----------------------------------------------------------------------------
// sclc_back
// Result builder: takes queue entries one cluster at a time and works out
// extent, midpoint and leg flags over three stages ending in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sclc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sclc_pkg::close_t  head,
	input  logic              head_valid,
	output logic              pop,
	input  sclc_pkg::cfg_t    cfg,
	output logic              clus_valid,
	input  logic              clus_ready,
	output sclc_pkg::result_t clus_data
);
	import sclc_pkg::*;

	logic gap_done_q, issue_gap, issue, ce_s1, ce_s2, ce_s3;
	rec_t rec;

	logic                         v_s1, last_s1;
	logic [MAG_W-1:0]             adx_s1, ady_s1;
	logic signed [COORD_BITS-1:0] midx_s1, midy_s1;
	logic [PROD_W-1:0]            pcnt_s1, mov100_s1;
	rec_t                         rec_s1;

	logic                         v_s2, last_s2;
	logic [SQ_W-1:0]              sqx_s2, sqy_s2;
	logic signed [COORD_BITS-1:0] midx_s2, midy_s2;
	logic [PROD_W-1:0]            pcnt_s2, mov100_s2;
	rec_t                         rec_s2;

	logic              v_s3;
	result_t           res_s3, res;
	logic [WIDE_W-1:0] ext_wide;
	logic [EXT_W-1:0]  ext;
	logic              leg;

	// stage enables, output register last
	assign ce_s3 = ~v_s3 | clus_ready;
	assign ce_s2 = ~v_s2 | ce_s3;
	assign ce_s1 = ~v_s1 | ce_s2;

	// pick gap-closed cluster first, then scan-end cluster
	assign issue_gap = ~gap_done_q & head.gap_v;
	assign rec       = issue_gap ? head.gap : head.fin;
	assign issue     = head_valid & ce_s1;
	assign pop       = issue & (~issue_gap | ~head.fin_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_done_q <= 1'b0;
		end else if (pop) begin
			gap_done_q <= 1'b0;
		end else if (issue && issue_gap) begin
			gap_done_q <= 1'b1;
		end
	end

	// stage 1: differences, midpoint, moving share products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce_s1) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rec_s1    <= rec;
			last_s1   <= ~issue_gap;
			adx_s1    <= abs_diff(rec.start_x, rec.end_x);
			ady_s1    <= abs_diff(rec.start_y, rec.end_y);
			midx_s1   <= half_sum(rec.start_x, rec.end_x);
			midy_s1   <= half_sum(rec.start_y, rec.end_y);
			pcnt_s1   <= PROD_W'(cfg.dynamic_percent) * PROD_W'(rec.cnt);
			mov100_s1 <= PROD_W'(rec.mov) * PROD_W'(PERCENT_SCALE);
		end
	end

	// stage 2: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce_s2 && v_s1) begin
			rec_s2    <= rec_s1;
			last_s2   <= last_s1;
			sqx_s2    <= SQ_W'(adx_s1 * adx_s1);
			sqy_s2    <= SQ_W'(ady_s1 * ady_s1);
			midx_s2   <= midx_s1;
			midy_s2   <= midy_s1;
			pcnt_s2   <= pcnt_s1;
			mov100_s2 <= mov100_s1;
		end
	end

	// stage 3: saturated extent and classification
	always_comb begin
		ext_wide = WIDE_W'(sqx_s2) + WIDE_W'(sqy_s2);
		ext      = (ext_wide > WIDE_W'(EXT_MAX)) ? EXT_MAX : EXT_W'(ext_wide);
		leg      = (ext >= cfg.leg_min_sq) & (ext <= cfg.leg_max_sq)
			& (rec_s2.cnt > CNT_W'(LEG_MIN_POINTS));
		res.cluster_number = rec_s2.cidx;
		res.first_beam     = rec_s2.start_idx;
		res.point_count    = rec_s2.cnt;
		res.extent_sq      = ext;
		res.middle_x       = midx_s2;
		res.middle_y       = midy_s2;
		res.moving_count   = rec_s2.mov;
		res.is_leg         = leg;
		res.leg_moving     = leg & (mov100_s2 >= pcnt_s2);
		res.last_cluster   = last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce_s3 && v_s2) begin
			res_s3 <= res;
		end
	end

	assign clus_valid = v_s3;
	assign clus_data  = res_s3;

endmodule

`default_nettype wire

### design/scan_cluster_leg_classifier_core.sv
// ----------------------------------------------------------------------------
// scan_cluster_leg_classifier_core
// Splits a laser scan into clusters at large beam-to-beam gaps and reports
// each closed cluster with its extent, midpoint and leg classification.
//
//   channel   | direction | handshake               | beat
//   ----------+-----------+-------------------------+---------------------
//   beam      | in        | beam_valid / beam_ready | sclc_pkg::beam_t
//   clus      | out       | clus_valid / clus_ready | sclc_pkg::result_t
//   registers | in/out    | psel/penable, pready=1  | 64-bit, 8-byte stride
//
// One beam beat per cycle while beam_ready is high; a beam closing two clusters
// hands both to the result builder in turn, the queue absorbing the difference.
// A beam beat passes two intake stages, a queue entry and three result stages
// including the output register.
// Reset clears all pipeline valids, the queue and the cluster state; registers
// take their default values. No clearing pass.
// A stalled result side fills the output stages and the four-entry queue
// before beam_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_cluster_leg_classifier_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        beam_valid,
	output logic                        beam_ready,
	input  sclc_pkg::beam_t             beam_data,
	output logic                        clus_valid,
	input  logic                        clus_ready,
	output sclc_pkg::result_t           clus_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sclc_pkg::ADDR_W-1:0] paddr,
	input  logic [sclc_pkg::DATA_W-1:0] pwdata,
	output logic [sclc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import sclc_pkg::*;

	cfg_t   cfg;
	close_t push_data, head;
	logic   push, full, pop, head_valid;

	// register bank
	sclc_csr u_csr (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// beam intake and cluster tracking
	sclc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.beam_valid (beam_valid),
		.beam_ready (beam_ready),
		.beam_data  (beam_data),
		.gap_sq     (cfg.gap_sq),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	// closed-cluster queue
	sclc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// result builder
	sclc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cfg        (cfg),
		.clus_valid (clus_valid),
		.clus_ready (clus_ready),
		.clus_data  (clus_data)
	);

endmodule

`default_nettype wire

### design/sclc_checker.sv
// ----------------------------------------------------------------------------
// sclc_checker
// Port-level checks of the scan cluster leg classifier, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sclc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clus_valid,
	input  logic                        clus_ready,
	input  sclc_pkg::result_t           clus_data
);
	import sclc_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clus_valid && !clus_ready |=> clus_valid && $stable(clus_data))
		else $error("result beat changed while stalled");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !clus_valid)
		else $error("result beat right after reset");

	// leg flags agree with each other and with the point count
	a_leg_flags: assert property (@(posedge clk) disable iff (!arst_n)
		clus_valid |-> (!clus_data.leg_moving || clus_data.is_leg)
			&& (!clus_data.is_leg
				|| clus_data.point_count > CNT_W'(LEG_MIN_POINTS)))
		else $error("leg flags inconsistent");

	// counts are sane
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		clus_valid |-> clus_data.point_count != '0
			&& clus_data.moving_count <= clus_data.point_count)
		else $error("cluster counts inconsistent");

endmodule

bind scan_cluster_leg_classifier_core sclc_checker u_sclc_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scan cluster leg classifier. Beams go in over a
// valid/ready channel with random gaps, and cluster beats come out under
// random back-pressure, with two long receiver hold-offs. A behavioral model of
// the clustering keeps its own scan state and thresholds, and queues the
// cluster beats that each accepted beam closes. Every output beat is compared
// field by field with the oldest queued one. A short directed table comes
// first, then random scans run under several threshold settings written over
// the register port, among them an over-long scan that closes on its own.
// ----------------------------------------------------------------------------

module tb_top;
	import sclc_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int DIR_ROWS      = 24;

	localparam logic signed [COORD_BITS-1:0] CORNER_COORDS [4] =
		'{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

	typedef struct {
		beam_t   beam;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              beam_valid = 1'b0;
	logic              beam_ready;
	beam_t             beam_data  = '0;
	logic              clus_valid;
	logic              clus_ready = 1'b0;
	result_t           clus_data;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [ADDR_W-1:0] paddr      = '0;
	logic [DATA_W-1:0] pwdata     = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// model copy of the thresholds
	logic [EXT_W-1:0] cfg_gap     = GAP_SQ_RST;
	logic [EXT_W-1:0] cfg_leg_min = LEG_MIN_RST;
	logic [EXT_W-1:0] cfg_leg_max = LEG_MAX_RST;
	logic [PCT_W-1:0] cfg_pct     = DYN_PCT_RST;

	// model copy of the open cluster and scan position
	logic signed [COORD_BITS-1:0] run_start_x = '0;
	logic signed [COORD_BITS-1:0] run_start_y = '0;
	logic signed [COORD_BITS-1:0] run_end_x   = '0;
	logic signed [COORD_BITS-1:0] run_end_y   = '0;
	logic [IDX_W-1:0]             run_first   = '0;
	logic [CNT_W-1:0]             run_count   = '0;
	logic [CNT_W-1:0]             run_moving  = '0;
	logic [IDX_W-1:0]             run_cluster = '0;
	int                           scan_pos    = 0;

	result_t cluster_expect_q [$];
	int      mismatches    = 0;
	int      clusters_seen = 0;

	// random walk position of the beam generator
	logic signed [COORD_BITS-1:0] walk_x = '0;
	logic signed [COORD_BITS-1:0] walk_y = '0;
	bit                           beam_burst = 1'b0;

	dir_row_t dir_table [DIR_ROWS];

	scan_cluster_leg_classifier_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.beam_valid (beam_valid),
		.beam_ready (beam_ready),
		.beam_data  (beam_data),
		.clus_valid (clus_valid),
		.clus_ready (clus_ready),
		.clus_data  (clus_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// clustering model
	// ------------------------------------------------------------------

	function automatic logic [63:0] dist_sq(
		input logic signed [COORD_BITS-1:0] ax,
		input logic signed [COORD_BITS-1:0] ay,
		input logic signed [COORD_BITS-1:0] bx,
		input logic signed [COORD_BITS-1:0] by
	);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// report of the open cluster, as it stands now
	function automatic result_t summarize_cluster(input bit closes_scan);
		result_t     r;
		logic [63:0] ext;
		ext = dist_sq(run_start_x, run_start_y, run_end_x, run_end_y);
		if (ext > 64'(EXT_MAX))
			ext = 64'(EXT_MAX);
		r.cluster_number = run_cluster;
		r.first_beam     = run_first;
		r.point_count    = run_count;
		r.extent_sq      = ext[EXT_W-1:0];
		r.middle_x       = COORD_BITS'((longint'(run_start_x) + longint'(run_end_x)) >>> 1);
		r.middle_y       = COORD_BITS'((longint'(run_start_y) + longint'(run_end_y)) >>> 1);
		r.moving_count   = run_moving;
		r.is_leg         = (ext >= 64'(cfg_leg_min)) && (ext <= 64'(cfg_leg_max))
			&& (run_count > LEG_MIN_POINTS);
		r.leg_moving     = r.is_leg && (64'(run_moving) * PERCENT_SCALE
			>= 64'(cfg_pct) * 64'(run_count));
		r.last_cluster   = closes_scan;
		return r;
	endfunction

	task automatic open_run(input beam_t b, input int idx);
		run_start_x = b.point_x;
		run_start_y = b.point_y;
		run_end_x   = b.point_x;
		run_end_y   = b.point_y;
		run_first   = IDX_W'(idx);
		run_count   = CNT_W'(1);
		run_moving  = CNT_W'(b.beam_moving);
	endtask

	// advance the model by one accepted beam, queue the clusters it closes
	task automatic classify_beam(input beam_t b);
		if (scan_pos == 0) begin
			run_cluster = '0;
			open_run(b, 0);
		end else if (dist_sq(b.point_x, b.point_y, run_end_x, run_end_y) > 64'(cfg_gap)) begin
			cluster_expect_q.push_back(summarize_cluster(1'b0));
			run_cluster++;
			open_run(b, scan_pos);
		end else begin
			run_count++;
			run_moving += CNT_W'(b.beam_moving);
			run_end_x = b.point_x;
			run_end_y = b.point_y;
		end
		scan_pos++;
		// final beam, or the scan ran out of beam slots
		if (b.last_beam || scan_pos >= MAX_BEAMS) begin
			cluster_expect_q.push_back(summarize_cluster(1'b1));
			scan_pos    = 0;
			run_cluster = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// beam side
	// ------------------------------------------------------------------

	task automatic send_beam(input beam_t b, input bit typed, input result_t want);
		int gap;
		if ($urandom_range(0, 49) == 0)
			beam_burst = !beam_burst;
		gap = beam_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			beam_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beam_valid <= 1'b1;
		beam_data  <= b;
		@(posedge clk);
		while (!beam_ready)
			@(posedge clk);
		classify_beam(b);
		// hand-written value replaces the model's for typed rows
		if (typed) begin
			void'(cluster_expect_q.pop_back());
			cluster_expect_q.push_back(want);
		end
	endtask

	// next beam of a random walk: mostly small steps, some repeats, jumps and corners
	function automatic beam_t next_beam(input bit closing);
		beam_t b;
		case ($urandom_range(0, 15))
			0: begin
				walk_x = CORNER_COORDS[$urandom_range(0, 3)];
				walk_y = CORNER_COORDS[$urandom_range(0, 3)];
			end
			1: begin
				walk_x = COORD_BITS'($urandom);
				walk_y = COORD_BITS'($urandom);
			end
			2, 3, 4: begin
			end
			13, 14, 15: begin
				walk_x = walk_x + COORD_BITS'($urandom_range(0, 4000) - 2000);
				walk_y = walk_y + COORD_BITS'($urandom_range(0, 4000) - 2000);
			end
			default: begin
				walk_x = walk_x + COORD_BITS'($urandom_range(0, 300) - 150);
				walk_y = walk_y + COORD_BITS'($urandom_range(0, 300) - 150);
			end
		endcase
		b.point_x     = walk_x;
		b.point_y     = walk_y;
		b.beam_moving = ($urandom_range(0, 3) != 0);
		b.last_beam   = closing;
		return b;
	endfunction

	// random scans of mostly short length; the phase always ends on a final beam
	task automatic random_scans(input int n_beams);
		int left_in_scan;
		left_in_scan = 0;
		for (int k = 0; k < n_beams; k++) begin
			if (left_in_scan == 0)
				left_in_scan = ($urandom_range(0, 7) == 0) ?
					$urandom_range(41, 120) : $urandom_range(1, 40);
			left_in_scan--;
			send_beam(next_beam(left_in_scan == 0 || k == n_beams - 1), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// wait for the block to go idle, then load a new set of thresholds
	task automatic load_thresholds(
		input logic [EXT_W-1:0] gap,
		input logic [EXT_W-1:0] leg_min,
		input logic [EXT_W-1:0] leg_max,
		input logic [PCT_W-1:0] pct
	);
		beam_valid <= 1'b0;
		while (cluster_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_GAP_SQ, DATA_W'(gap));
		write_reg(REG_LEG_MIN, DATA_W'(leg_min));
		write_reg(REG_LEG_MAX, DATA_W'(leg_max));
		write_reg(REG_DYN_PCT, DATA_W'(pct));
		cfg_gap     = gap;
		cfg_leg_min = leg_min;
		cfg_leg_max = leg_max;
		cfg_pct     = pct;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// cluster side
	// ------------------------------------------------------------------

	task automatic check_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	initial begin
		int      gap;
		bit      burst;
		result_t want;
		burst = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				burst = !burst;
			gap = burst ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				clus_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			clus_ready <= 1'b1;
			@(posedge clk);
			while (!clus_valid)
				@(posedge clk);
			clusters_seen++;
			if (cluster_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected cluster beat %p", $time, clus_data);
			end else begin
				want = cluster_expect_q.pop_front();
				check_field("cluster_number", want.cluster_number, clus_data.cluster_number);
				check_field("first_beam", want.first_beam, clus_data.first_beam);
				check_field("point_count", want.point_count, clus_data.point_count);
				check_field("extent_sq", want.extent_sq, clus_data.extent_sq);
				check_field("middle_x", longint'(want.middle_x), longint'(clus_data.middle_x));
				check_field("middle_y", longint'(want.middle_y), longint'(clus_data.middle_y));
				check_field("moving_count", want.moving_count, clus_data.moving_count);
				check_field("is_leg", want.is_leg, clus_data.is_leg);
				check_field("leg_moving", want.leg_moving, clus_data.leg_moving);
				check_field("last_cluster", want.last_cluster, clus_data.last_cluster);
			end
			// long hold-off so the beam side backs up
			if (clusters_seen == 60 || clusters_seen == 500) begin
				clus_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		// single-beam scans at the coordinate corners
		dir_table[0]  = '{'{16'h7fff, 16'h8000, 1'b1, 1'b1}, 1'b1,
			'{10'd0, 10'd0, 11'd1, 33'd0, 16'h7fff, 16'h8000, 11'd1, 1'b0, 1'b0, 1'b1}};
		dir_table[1]  = '{'{16'h8000, 16'h7fff, 1'b0, 1'b1}, 1'b1,
			'{10'd0, 10'd0, 11'd1, 33'd0, 16'h8000, 16'h7fff, 11'd0, 1'b0, 1'b0, 1'b1}};
		// two beams, midpoint rounds toward minus infinity
		dir_table[2]  = '{'{-16'sd3, 16'sd5, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[3]  = '{'{16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b1,
			'{10'd0, 10'd0, 11'd2, 33'd34, -16'sd2, 16'sd2, 11'd1, 1'b0, 1'b0, 1'b1}};
		// seven-beam moving leg, closed by a gap on the final beam
		dir_table[4]  = '{'{16'sd0, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[5]  = '{'{16'sd30, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[6]  = '{'{16'sd60, -16'sd1000, 1'b0, 1'b0}, 1'b0, '0};
		dir_table[7]  = '{'{16'sd90, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[8]  = '{'{16'sd120, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[9]  = '{'{16'sd150, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[10] = '{'{16'sd180, -16'sd1000, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[11] = '{'{16'sd20000, 16'sd20000, 1'b0, 1'b1}, 1'b0, '0};
		// eight-beam leg with the moving share exactly at the threshold
		dir_table[12] = '{'{16'sd500, 16'sd0, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[13] = '{'{16'sd500, 16'sd20, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[14] = '{'{16'sd500, 16'sd40, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[15] = '{'{16'sd500, 16'sd60, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[16] = '{'{16'sd500, 16'sd80, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[17] = '{'{16'sd500, 16'sd100, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[18] = '{'{16'sd500, 16'sd120, 1'b0, 1'b0}, 1'b0, '0};
		dir_table[19] = '{'{16'sd500, 16'sd140, 1'b0, 1'b1}, 1'b0, '0};
		// gap well above the threshold splits, gap equal to it does not
		dir_table[20] = '{'{16'sd100, 16'sd100, 1'b0, 1'b0}, 1'b0, '0};
		dir_table[21] = '{'{-16'sd100, -16'sd100, 1'b0, 1'b0}, 1'b0, '0};
		dir_table[22] = '{'{-16'sd100, 16'sd100, 1'b1, 1'b0}, 1'b0, '0};
		dir_table[23] = '{'{-16'sd100, 16'sd100, 1'b1, 1'b1}, 1'b0, '0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_beam(dir_table[i].beam, dir_table[i].typed, dir_table[i].want);

		// reset thresholds
		random_scans(200);
		// every differing beam splits, every extent is in range, any share moves
		load_thresholds('0, '0, EXT_MAX, '0);
		random_scans(150);
		// one cluster per scan, full share needed
		load_thresholds(EXT_MAX, '0, EXT_MAX, PCT_W'(100));
		random_scans(150);
		// leg window pinned at the top, share above a hundred percent
		load_thresholds(EXT_W'(40000), EXT_MAX, EXT_MAX, '1);
		random_scans(150);
		load_thresholds(EXT_W'($urandom_range(5000, 90000)), EXT_W'($urandom_range(0, 5000)),
			EXT_W'($urandom_range(20000, 100000)), PCT_W'($urandom_range(0, 100)));
		random_scans(150);
		// scan longer than the beam slots, closes on its own
		load_thresholds(EXT_W'(90000), EXT_W'(2500), EXT_W'(62500), PCT_W'(75));
		for (int k = 0; k < MAX_BEAMS + 6; k++)
			send_beam(next_beam(k == MAX_BEAMS + 5), 1'b0, '0);
		random_scans(120);

		beam_valid <= 1'b0;
		while (cluster_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
design/sclc_pkg.sv
design/sclc_csr.sv
design/sclc_front.sv
design/sclc_queue.sv
design/sclc_back.sv
design/scan_cluster_leg_classifier_core.sv
design/sclc_checker.sv
sim/tb_top.sv
